>>> sv/mpbd_pkg.sv
// Shared types, register indexes and constants for the multi-press button decoder.
package mpbd_pkg;

    localparam int TIME_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 3;

    localparam int CFG_WIDTH       = 32;
    localparam int CFG_ADDR_WIDTH  = 2;
    localparam int TICKS_WIDTH     = 32;
    localparam int IN_TDATA_WIDTH  = 40;
    localparam int OUT_TDATA_WIDTH = 24;
    localparam int RESULT_WIDTH    = 21;

    typedef logic [CFG_ADDR_WIDTH-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_DEBOUNCE   = 2'd0;
    localparam cfg_addr_t REG_LONG_PRESS = 2'd1;
    localparam cfg_addr_t REG_GAP        = 2'd2;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 32'd327;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 32'd65536;
    localparam logic [CFG_WIDTH-1:0] GAP_RESET        = 32'd65536;

    localparam logic [6:0] DUST_HIGH = 7'd100;
    localparam logic [6:0] DUST_MID  = 7'd50;
    localparam logic [6:0] DUST_LOW  = 7'd10;

    typedef enum logic [2:0] {
        CMD_RESET     = 3'd0,
        CMD_SENSING   = 3'd1,
        CMD_DUST_HIGH = 3'd2,
        CMD_DUST_MID  = 3'd3,
        CMD_DUST_LOW  = 3'd4,
        CMD_HEARTBEAT = 3'd5,
        CMD_RADIO     = 3'd6,
        CMD_SEND      = 3'd7
    } cmd_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] debounce_ticks;
        logic [CFG_WIDTH-1:0] long_press_ticks;
        logic [CFG_WIDTH-1:0] gap_ticks;
    } cfg_t;

    // Declared from the highest bit down so the packed struct matches the tdata layout.
    typedef struct packed {
        logic [6:0] dust_sample_count;
        logic       radio_enabled;
        logic       heartbeat_enabled;
        logic       sensing_enabled;
        logic       send_now;
        logic       reset_request;
        logic [2:0] action_code;
        logic       action_valid;
        logic [2:0] press_count;
        logic       is_pressed;
        logic       accepted;
    } result_t;

endpackage

>>> sv/multi_press_button_decoder.sv
// Top level: input word register, edge decode, result register and configuration port.
//
//  Channel   Direction  Word contents (low bit first)
//  s_axis    in         pin_level, now_ticks[31:0], zero fill
//  m_axis    out        accepted, is_pressed, press_count, action_valid, action_code,
//                       reset_request, send_now, sensing, heartbeat, radio, dust, zero fill
//  cfg       in         write only: 0 debounce, 1 long press, 2 gap
//
// Every input word yields exactly one result word, via input and result registers.
// One word is accepted per cycle unless m_axis stalls; the decode reads and updates
// its state in the same cycle the word leaves the input register. Reset clears the
// handshake state and returns all thresholds and button state to their defaults.
// A stall on m_axis holds the result register and, one word later, the input.
module multi_press_button_decoder
#(
    parameter int TIME_WIDTH  = mpbd_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = mpbd_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // pin_level [0], now_ticks [32:1], zero [39:33]
    input  logic [mpbd_pkg::IN_TDATA_WIDTH-1:0]      s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // accepted [0], is_pressed [1], press_count [4:2], action_valid [5],
    // action_code [8:6], reset_request [9], send_now [10], sensing_enabled [11],
    // heartbeat_enabled [12], radio_enabled [13], dust_sample_count [20:14], zero [23:21]
    output logic [mpbd_pkg::OUT_TDATA_WIDTH-1:0]     m_axis_tdata,
    input  logic                                     cfg_we,
    input  mpbd_pkg::cfg_addr_t                      cfg_addr,
    input  logic [mpbd_pkg::CFG_WIDTH-1:0]           cfg_wdata
);

    logic                                    in_valid_reg, in_valid_next;
    logic                                    level_reg;
    logic [mpbd_pkg::TICKS_WIDTH-1:0]        now_reg;
    logic                                    out_valid_reg, out_valid_next;
    mpbd_pkg::result_t                       out_reg;
    mpbd_pkg::result_t                       result;
    mpbd_pkg::cfg_t                          cfg;
    logic                                    advance;
    logic                                    fire;
    logic                                    s_fire;

    always_comb
    begin
        advance        = !out_valid_reg || m_axis_tready;
        fire           = in_valid_reg && advance;
        s_axis_tready  = !in_valid_reg || advance;
        s_fire         = s_axis_tvalid && s_axis_tready;
        in_valid_next  = s_fire || (in_valid_reg && !fire);
        out_valid_next = fire || (out_valid_reg && !m_axis_tready);
    end

    mpbd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mpbd_decode
    #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .pin_level (level_reg),
        .now_ticks (now_reg),
        .cfg       (cfg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            level_reg <= s_axis_tdata[0];
            now_reg   <= s_axis_tdata[mpbd_pkg::TICKS_WIDTH:1];
        end
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(mpbd_pkg::OUT_TDATA_WIDTH - mpbd_pkg::RESULT_WIDTH){1'b0}},
                            out_reg};

endmodule

>>> sv/mpbd_cfg_regs.sv
// Configuration register file: debounce, long-press and gap thresholds.
module mpbd_cfg_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  mpbd_pkg::cfg_addr_t                   cfg_addr,
    input  logic [mpbd_pkg::CFG_WIDTH-1:0]        cfg_wdata,
    output mpbd_pkg::cfg_t                        cfg
);

    mpbd_pkg::cfg_t cfg_reg;
    mpbd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                mpbd_pkg::REG_DEBOUNCE:   cfg_next.debounce_ticks   = cfg_wdata;
                mpbd_pkg::REG_LONG_PRESS: cfg_next.long_press_ticks = cfg_wdata;
                mpbd_pkg::REG_GAP:        cfg_next.gap_ticks        = cfg_wdata;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= mpbd_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ticks <= mpbd_pkg::LONG_PRESS_RESET;
            cfg_reg.gap_ticks        <= mpbd_pkg::GAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/mpbd_decode.sv
// Button state registers and the single-pass edge decode that updates them.
module mpbd_decode
#(
    parameter int TIME_WIDTH  = mpbd_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = mpbd_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  logic                                pin_level,
    input  logic [mpbd_pkg::TICKS_WIDTH-1:0]    now_ticks,
    input  mpbd_pkg::cfg_t                      cfg,
    output mpbd_pkg::result_t                   result
);

    localparam int CMP_W  = (TIME_WIDTH > mpbd_pkg::CFG_WIDTH) ? TIME_WIDTH
                                                               : mpbd_pkg::CFG_WIDTH;
    localparam int CODE_W = (COUNT_WIDTH > 3) ? COUNT_WIDTH : 3;

    logic                   pressed_reg,    pressed_next;
    logic                   edge_seen_reg,  edge_seen_next;
    logic [COUNT_WIDTH-1:0] count_reg,      count_next;
    logic [TIME_WIDTH-1:0]  press_time_reg, press_time_next;
    logic [TIME_WIDTH-1:0]  rel_time_reg,   rel_time_next;
    logic                   sensing_reg,    sensing_next;
    logic                   heartbeat_reg,  heartbeat_next;
    logic                   radio_reg,      radio_next;
    logic [6:0]             dust_reg,       dust_next;

    logic [TIME_WIDTH-1:0]  now_t;
    logic [TIME_WIDTH-1:0]  elapsed;
    logic [TIME_WIDTH-1:0]  gap;
    logic                   too_soon;
    logic                   take;
    logic                   act_valid;
    logic                   rst_req;
    logic                   send;
    logic [CODE_W-1:0]      code_ext;
    logic [CODE_W-1:0]      count_ext;

    always_comb
    begin
        now_t   = TIME_WIDTH'(now_ticks);
        elapsed = now_t - (pressed_reg ? press_time_reg : rel_time_reg);
        gap     = now_t - rel_time_reg;
        // Before the first accepted edge there is no reference time to debounce against.
        too_soon = (CMP_W'(elapsed) < CMP_W'(cfg.debounce_ticks)) && edge_seen_reg;
        take     = (pin_level != pressed_reg) && !too_soon;

        pressed_next    = pressed_reg;
        edge_seen_next  = edge_seen_reg;
        count_next      = count_reg;
        press_time_next = press_time_reg;
        rel_time_next   = rel_time_reg;
        sensing_next    = sensing_reg;
        heartbeat_next  = heartbeat_reg;
        radio_next      = radio_reg;
        dust_next       = dust_reg;
        act_valid       = 1'b0;
        rst_req         = 1'b0;
        send            = 1'b0;
        code_ext        = '0;

        if (take)
        begin
            pressed_next   = pin_level;
            edge_seen_next = 1'b1;
            if (!pin_level)
            begin
                rel_time_next = now_t;
                if (CMP_W'(elapsed) < CMP_W'(cfg.long_press_ticks))
                begin
                    count_next = count_reg + COUNT_WIDTH'(1);
                end
                else
                begin
                    act_valid  = 1'b1;
                    code_ext   = CODE_W'(count_reg);
                    count_next = '0;
                    case (code_ext)
                        CODE_W'(mpbd_pkg::CMD_RESET):     rst_req        = 1'b1;
                        CODE_W'(mpbd_pkg::CMD_SENSING):   sensing_next   = !sensing_reg;
                        CODE_W'(mpbd_pkg::CMD_DUST_HIGH): dust_next      = mpbd_pkg::DUST_HIGH;
                        CODE_W'(mpbd_pkg::CMD_DUST_MID):  dust_next      = mpbd_pkg::DUST_MID;
                        CODE_W'(mpbd_pkg::CMD_DUST_LOW):  dust_next      = mpbd_pkg::DUST_LOW;
                        CODE_W'(mpbd_pkg::CMD_HEARTBEAT): heartbeat_next = !heartbeat_reg;
                        CODE_W'(mpbd_pkg::CMD_RADIO):     radio_next     = !radio_reg;
                        CODE_W'(mpbd_pkg::CMD_SEND):      send           = 1'b1;
                        default:                          send           = 1'b0;
                    endcase
                end
            end
            else
            begin
                press_time_next = now_t;
                if (CMP_W'(gap) > CMP_W'(cfg.gap_ticks))
                begin
                    count_next = '0;
                end
            end
        end

        count_ext = CODE_W'(count_next);

        result.accepted          = take;
        result.is_pressed        = pressed_next;
        result.press_count       = count_ext[2:0];
        result.action_valid      = act_valid;
        result.action_code       = code_ext[2:0];
        result.reset_request     = rst_req;
        result.send_now          = send;
        result.sensing_enabled   = sensing_next;
        result.heartbeat_enabled = heartbeat_next;
        result.radio_enabled     = radio_next;
        result.dust_sample_count = dust_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg    <= 1'b0;
            edge_seen_reg  <= 1'b0;
            count_reg      <= '0;
            press_time_reg <= '0;
            rel_time_reg   <= '0;
            sensing_reg    <= 1'b1;
            heartbeat_reg  <= 1'b1;
            radio_reg      <= 1'b1;
            dust_reg       <= mpbd_pkg::DUST_MID;
        end
        else if (fire)
        begin
            pressed_reg    <= pressed_next;
            edge_seen_reg  <= edge_seen_next;
            count_reg      <= count_next;
            press_time_reg <= press_time_next;
            rel_time_reg   <= rel_time_next;
            sensing_reg    <= sensing_next;
            heartbeat_reg  <= heartbeat_next;
            radio_reg      <= radio_next;
            dust_reg       <= dust_next;
        end
    end

endmodule

>>> sv/mpbd_checker.sv
// Port-level checker for the multi-press button decoder, bound to the top level.
module mpbd_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [mpbd_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata
);

    // A result word that is held back must not change or vanish.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // A command only runs on an accepted release.
    a_action_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[0] && !m_axis_tdata[1])
        else $error("command without an accepted release");

    // The pulses belong to a command and cannot both fire.
    a_pulses: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[9] || m_axis_tdata[10])
            |-> m_axis_tdata[5] && !(m_axis_tdata[9] && m_axis_tdata[10]))
        else $error("reset or send pulse without a command");

    a_dust_setting: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[20:14] == mpbd_pkg::DUST_HIGH)
                       || (m_axis_tdata[20:14] == mpbd_pkg::DUST_MID)
                       || (m_axis_tdata[20:14] == mpbd_pkg::DUST_LOW))
        else $error("dust sample setting out of its set");

endmodule

bind multi_press_button_decoder mpbd_checker u_mpbd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/tb_multi_press_button_decoder.sv
// Self-checking testbench for the multi-press button decoder: directed edge cases, then random press sequences.
module tb_multi_press_button_decoder;

    localparam mpbd_pkg::cfg_addr_t REG_UNUSED = 2'd3;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    // pin_level [0], now_ticks [32:1], zero [39:33]
    logic [mpbd_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata = '0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    // accepted [0], is_pressed [1], press_count [4:2], action_valid [5],
    // action_code [8:6], reset_request [9], send_now [10], sensing_enabled [11],
    // heartbeat_enabled [12], radio_enabled [13], dust_sample_count [20:14], zero [23:21]
    logic [mpbd_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata;
    logic                                 cfg_we = 1'b0;
    mpbd_pkg::cfg_addr_t                  cfg_addr = mpbd_pkg::REG_DEBOUNCE;
    logic [mpbd_pkg::CFG_WIDTH-1:0]       cfg_wdata = '0;

    multi_press_button_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // Decoder state as the testbench predicts it.
    logic        btn_down       = 1'b0;
    logic [2:0]  press_tally    = 3'd0;
    logic [31:0] press_stamp    = '0;
    logic [31:0] release_stamp  = '0;
    logic        sensing_on     = 1'b1;
    logic        heartbeat_on   = 1'b1;
    logic        radio_on       = 1'b1;
    logic [6:0]  dust_setting   = mpbd_pkg::DUST_MID;
    logic        edge_seen_once = 1'b0;
    logic [31:0] debounce_cfg   = mpbd_pkg::DEBOUNCE_RESET;
    logic [31:0] long_cfg       = mpbd_pkg::LONG_PRESS_RESET;
    logic [31:0] gap_cfg        = mpbd_pkg::GAP_RESET;

    mpbd_pkg::result_t pending_results[$];
    logic [31:0] tick_now = '0;
    bit          steady_flow = 1'b0;
    int          mismatches = 0;
    int          sent_events = 0;
    int          accepted_events = 0;
    int          commands_run = 0;
    int          settings_used = 0;

    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 34);
    end

    // Works out the result of one button event and advances the predicted state.
    function automatic mpbd_pkg::result_t decode_event(input logic level,
                                                       input logic [31:0] stamp);
        mpbd_pkg::result_t r;
        logic [31:0]       elapsed;
        logic [31:0]       idle_gap;
        r = '0;
        if (level != btn_down)
        begin
            elapsed = stamp - (btn_down ? press_stamp : release_stamp);
            if (!(elapsed < debounce_cfg && edge_seen_once))
            begin
                r.accepted = 1'b1;
                edge_seen_once = 1'b1;
                btn_down = level;
                if (!level)
                begin
                    if (elapsed < long_cfg)
                        press_tally = press_tally + 3'd1;
                    else
                    begin
                        r.action_valid = 1'b1;
                        r.action_code = press_tally;
                        press_tally = 3'd0;
                        commands_run++;
                        case (mpbd_pkg::cmd_t'(r.action_code))
                            mpbd_pkg::CMD_RESET:     r.reset_request = 1'b1;
                            mpbd_pkg::CMD_SENSING:   sensing_on = !sensing_on;
                            mpbd_pkg::CMD_DUST_HIGH: dust_setting = mpbd_pkg::DUST_HIGH;
                            mpbd_pkg::CMD_DUST_MID:  dust_setting = mpbd_pkg::DUST_MID;
                            mpbd_pkg::CMD_DUST_LOW:  dust_setting = mpbd_pkg::DUST_LOW;
                            mpbd_pkg::CMD_HEARTBEAT: heartbeat_on = !heartbeat_on;
                            mpbd_pkg::CMD_RADIO:     radio_on = !radio_on;
                            mpbd_pkg::CMD_SEND:      r.send_now = 1'b1;
                            default:                 ;
                        endcase
                    end
                    release_stamp = stamp;
                end
                else
                begin
                    idle_gap = stamp - release_stamp;
                    if (idle_gap > gap_cfg)
                        press_tally = 3'd0;
                    press_stamp = stamp;
                end
            end
        end
        r.is_pressed = btn_down;
        r.press_count = press_tally;
        r.sensing_enabled = sensing_on;
        r.heartbeat_enabled = heartbeat_on;
        r.radio_enabled = radio_on;
        r.dust_sample_count = dust_setting;
        return r;
    endfunction

    always @(posedge clk)
    begin : check_result
        mpbd_pkg::result_t got;
        mpbd_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[mpbd_pkg::RESULT_WIDTH-1:0];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h with nothing pending", m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.accepted !== want.accepted || got.is_pressed !== want.is_pressed ||
                    got.press_count !== want.press_count ||
                    got.action_valid !== want.action_valid ||
                    got.action_code !== want.action_code ||
                    got.reset_request !== want.reset_request ||
                    got.send_now !== want.send_now ||
                    got.sensing_enabled !== want.sensing_enabled ||
                    got.heartbeat_enabled !== want.heartbeat_enabled ||
                    got.radio_enabled !== want.radio_enabled ||
                    got.dust_sample_count !== want.dust_sample_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result mismatch at %0t", $time);
                        $display("  expected acc=%0d prs=%0d cnt=%0d act=%0d code=%0d rst=%0d",
                                 want.accepted, want.is_pressed, want.press_count,
                                 want.action_valid, want.action_code, want.reset_request);
                        $display("           send=%0d sns=%0d hb=%0d rad=%0d dust=%0d",
                                 want.send_now, want.sensing_enabled, want.heartbeat_enabled,
                                 want.radio_enabled, want.dust_sample_count);
                        $display("  actual   acc=%0d prs=%0d cnt=%0d act=%0d code=%0d rst=%0d",
                                 got.accepted, got.is_pressed, got.press_count,
                                 got.action_valid, got.action_code, got.reset_request);
                        $display("           send=%0d sns=%0d hb=%0d rad=%0d dust=%0d",
                                 got.send_now, got.sensing_enabled, got.heartbeat_enabled,
                                 got.radio_enabled, got.dust_sample_count);
                    end
                end
            end
        end
    end

    // Offers one event word and records its expected result once it is taken.
    task automatic send_event(input logic level, input logic [31:0] stamp);
        mpbd_pkg::result_t want;
        while (!steady_flow && $urandom_range(0, 99) < 34)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, stamp, level};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        want = decode_event(level, stamp);
        pending_results.push_back(want);
        sent_events++;
        if (want.accepted)
            accepted_events++;
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0d results still outstanding after drain", pending_results.size());
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input mpbd_pkg::cfg_addr_t idx, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            mpbd_pkg::REG_DEBOUNCE:   debounce_cfg = value;
            mpbd_pkg::REG_LONG_PRESS: long_cfg = value;
            mpbd_pkg::REG_GAP:        gap_cfg = value;
            default:                  ;
        endcase
    endtask

    task automatic set_thresholds(input logic [31:0] debounce, input logic [31:0] long_press,
                                  input logic [31:0] gap);
        wait_drained();
        write_register(mpbd_pkg::REG_DEBOUNCE, debounce);
        write_register(mpbd_pkg::REG_LONG_PRESS, long_press);
        write_register(mpbd_pkg::REG_GAP, gap);
        settings_used++;
    endtask

    // A well-formed sequence: some short presses, then a long press that runs the command.
    // Needs debounce_cfg < long_cfg and debounce_cfg <= gap_cfg.
    task automatic run_command(input int shorts);
        int i;
        if (btn_down)
        begin
            tick_now = tick_now + debounce_cfg + $urandom_range(0, 100);
            send_event(1'b0, tick_now);
        end
        if ($urandom_range(0, 3) != 0)
            tick_now = tick_now + gap_cfg + 1 + $urandom_range(0, 500);
        else
            tick_now = tick_now + $urandom_range(debounce_cfg, gap_cfg);
        for (i = 0; i < shorts; i++)
        begin
            send_event(1'b1, tick_now);
            tick_now = tick_now + $urandom_range(debounce_cfg, long_cfg - 1);
            send_event(1'b0, tick_now);
            tick_now = tick_now + $urandom_range(debounce_cfg, gap_cfg);
        end
        send_event(1'b1, tick_now);
        tick_now = tick_now + long_cfg + $urandom_range(0, 1000);
        send_event(1'b0, tick_now);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0:       tick_now = $urandom;
            1:       tick_now = tick_now + $urandom_range(0, debounce_cfg);
            default: tick_now = tick_now + $urandom_range(0, 2 * long_cfg);
        endcase
        send_event(1'($urandom_range(0, 1)), tick_now);
    endtask

    // Same-level event, the very first edge, debounce and long-press boundaries.
    task automatic test_first_edge_and_debounce();
        send_event(1'b0, 32'd5);
        send_event(1'b1, 32'd10);
        send_event(1'b0, 32'd100);
        send_event(1'b0, 32'd337);
        send_event(1'b1, 32'd663);
        send_event(1'b1, 32'd664);
        send_event(1'b0, 32'd664 + mpbd_pkg::LONG_PRESS_RESET);
        tick_now = 32'd664 + mpbd_pkg::LONG_PRESS_RESET;
    endtask

    // A press exactly gap_ticks after release keeps the count, one tick later clears it.
    task automatic test_gap_clear();
        tick_now = tick_now + 1000;
        send_event(1'b1, tick_now);
        tick_now = tick_now + 1000;
        send_event(1'b0, tick_now);
        tick_now = tick_now + mpbd_pkg::GAP_RESET;
        send_event(1'b1, tick_now);
        tick_now = tick_now + 1000;
        send_event(1'b0, tick_now);
        tick_now = tick_now + mpbd_pkg::GAP_RESET + 1;
        send_event(1'b1, tick_now);
        tick_now = tick_now + 1000;
        send_event(1'b0, tick_now);
    endtask

    task automatic test_tick_wrap();
        tick_now = 32'hFFFF_FFF0;
        send_event(1'b1, tick_now);
        tick_now = tick_now + 32'h100;
        send_event(1'b0, tick_now);
    endtask

    task automatic test_threshold_extremes();
        int i;
        // Everything zero: every release is long and the count never builds up.
        set_thresholds('0, '0, '0);
        for (i = 0; i < 6; i++)
        begin
            tick_now = tick_now + $urandom_range(0, 3);
            send_event(i % 2 == 0, tick_now);
        end
        // Debounce at zero, long press and gap at the top: short presses pile up and wrap the count.
        set_thresholds('0, '1, '1);
        write_register(REG_UNUSED, $urandom);
        for (i = 0; i < 9; i++)
        begin
            tick_now = tick_now + $urandom_range(0, 50);
            send_event(1'b1, tick_now);
            tick_now = tick_now + $urandom_range(0, 50);
            send_event(1'b0, tick_now);
        end
        tick_now = tick_now + 7;
        send_event(1'b1, tick_now);
        tick_now = tick_now - 1;
        send_event(1'b0, tick_now);
        // All at the top: only an edge one tick behind the last accepted edge gets through.
        set_thresholds('1, '1, '1);
        send_event(1'b1, tick_now + 5);
        tick_now = tick_now - 1;
        send_event(1'b1, tick_now);
        send_event(1'b0, tick_now + 100);
        tick_now = tick_now - 1;
        send_event(1'b0, tick_now);
    endtask

    task automatic test_random_sequences(input int target);
        int goal;
        int next_reconfig;
        logic [31:0] debounce;
        logic [31:0] long_press;
        goal = accepted_events + target;
        next_reconfig = accepted_events;
        while (accepted_events < goal)
        begin
            if (accepted_events >= next_reconfig)
            begin
                debounce = $urandom_range(0, 400);
                long_press = debounce + $urandom_range(1, 3000);
                set_thresholds(debounce, long_press, $urandom_range(debounce, debounce + 6000));
                next_reconfig = accepted_events + 200;
            end
            steady_flow = (goal - accepted_events) < 600 && (goal - accepted_events) >= 400;
            if ($urandom_range(0, 99) < 80)
                run_command($urandom_range(0, 10));
            else
                repeat ($urandom_range(1, 4)) send_noise();
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_edge_and_debounce();
        test_gap_clear();
        test_tick_wrap();
        test_threshold_extremes();
        test_random_sequences(1000);
        wait_drained();
        $display("Sent %0d button events, %0d taken as edges, %0d commands run,",
                 sent_events, accepted_events, commands_run);
        $display("under %0d threshold settings with random stalls on both sides.",
                 settings_used + 1);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
sv/mpbd_pkg.sv
sv/mpbd_cfg_regs.sv
sv/mpbd_decode.sv
sv/multi_press_button_decoder.sv
sv/mpbd_checker.sv
tb/sv/tb_multi_press_button_decoder.sv
